### hw/rtl/spid_pkg.sv
// Shared types, constants and helpers for the steering PID controller.
// Used by the divider, register file and top level.
package spid_pkg;

	localparam int ADC_BITS  = 12;
	localparam int PADDR_W   = 5;

	localparam logic [11:0] MID_SCALE     = 12'd2048;
	localparam logic [11:0] FULL_SCALE    = 12'd4095;
	localparam logic [11:0] COMMAND_LIMIT = 12'd400;
	localparam logic [12:0] WINDOW        = 13'd100;
	localparam logic signed [12:0] DEADBAND = 13'sd400;

	typedef enum logic [2:0] {
		REG_POT_MIDDLE = 3'd0,
		REG_POT_LEFT   = 3'd1,
		REG_POT_RIGHT  = 3'd2,
		REG_GAIN_P     = 3'd3,
		REG_GAIN_I     = 3'd4,
		REG_GAIN_D     = 3'd5,
		REG_TICK_RATE  = 3'd6,
		REG_UNUSED     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [11:0]        pot_middle;
		logic [11:0]        pot_left;
		logic [11:0]        pot_right;
		logic signed [15:0] gain_p;
		logic signed [15:0] gain_i;
		logic signed [15:0] gain_d;
		logic [15:0]        ticks_per_second;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic        short_op;   // 24 quotient bits instead of 32
		logic [31:0] dividend;
		logic [32:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
		logic [32:0] rem;
	} div_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
		logic signed [31:0] r;
		if (v > 51'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -51'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

### hw/rtl/spid_div.sv
// Restoring divider, one quotient bit per cycle, 24 or 32 steps.
// Depends on spid_pkg for the request and response structs.
module spid_div (
	input  logic              clk,
	input  logic              arst_n,
	input  spid_pkg::div_req_t req,
	output spid_pkg::div_rsp_t rsp
);
	import spid_pkg::*;

	logic [5:0]  cnt_q;
	logic [31:0] quot_q;
	logic [32:0] rem_q;
	logic        done_q;
	logic [34:0] trial;

	assign trial = {1'b0, rem_q, quot_q[31]} - {2'b00, req.divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			quot_q <= '0;
			rem_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 6'd1);
			if (req.start) begin
				rem_q <= '0;
				if (req.short_op) begin
					quot_q <= {req.dividend[23:0], 8'h00};
					cnt_q  <= 6'd24;
				end else begin
					quot_q <= req.dividend;
					cnt_q  <= 6'd32;
				end
			end else if (cnt_q != 6'd0) begin
				cnt_q <= cnt_q - 6'd1;
				if (!trial[34]) begin
					rem_q  <= trial[32:0];
					quot_q <= {quot_q[30:0], 1'b1};
				end else begin
					rem_q  <= {rem_q[31:0], quot_q[31]};
					quot_q <= {quot_q[30:0], 1'b0};
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;
endmodule

### hw/rtl/spid_mul.sv
// Shared signed multiplier, 17 x 34 bits, product registered.
// No package dependency.
module spid_mul (
	input  logic               clk,
	input  logic signed [16:0] a,
	input  logic signed [33:0] b,
	output logic signed [50:0] prod
);
	logic signed [50:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 51'(a * b);
	end

	assign prod = prod_q;
endmodule

### hw/rtl/spid_cfg.sv
// APB register file for calibration points, gains and tick rate.
// Depends on spid_pkg for cfg_t and register indexes.
module spid_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [spid_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output spid_pkg::cfg_t                cfg
);
	import spid_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pot_middle       <= 12'd2048;
			cfg_q.pot_left         <= 12'd4095;
			cfg_q.pot_right        <= 12'd0;
			cfg_q.gain_p           <= 16'sd256;
			cfg_q.gain_i           <= 16'sd0;
			cfg_q.gain_d           <= 16'sd0;
			cfg_q.ticks_per_second <= 16'd1000;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_POT_MIDDLE: cfg_q.pot_middle       <= pwdata[11:0];
				REG_POT_LEFT:   cfg_q.pot_left         <= pwdata[11:0];
				REG_POT_RIGHT:  cfg_q.pot_right        <= pwdata[11:0];
				REG_GAIN_P:     cfg_q.gain_p           <= pwdata[15:0];
				REG_GAIN_I:     cfg_q.gain_i           <= pwdata[15:0];
				REG_GAIN_D:     cfg_q.gain_d           <= pwdata[15:0];
				REG_TICK_RATE:  cfg_q.ticks_per_second <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_POT_MIDDLE: prdata = {20'h0, cfg_q.pot_middle};
			REG_POT_LEFT:   prdata = {20'h0, cfg_q.pot_left};
			REG_POT_RIGHT:  prdata = {20'h0, cfg_q.pot_right};
			REG_GAIN_P:     prdata = {16'h0, cfg_q.gain_p};
			REG_GAIN_I:     prdata = {16'h0, cfg_q.gain_i};
			REG_GAIN_D:     prdata = {16'h0, cfg_q.gain_d};
			REG_TICK_RATE:  prdata = {16'h0, cfg_q.ticks_per_second};
			default:        prdata = 32'h0;
		endcase
	end

	assign cfg = cfg_q;
endmodule

### hw/rtl/steering_pid_controller.sv
// Steering PID controller: sequencer around one divider and one multiplier.
// Depends on spid_pkg, spid_cfg, spid_div and spid_mul.
//
//   channel  | handshake            | payload
//   sample   | in_valid / in_stall  | position_sample, left_command, right_command,
//            |                      | elapsed_ticks
//   result   | out_valid / out_stall| position_error, drive_value
//   config   | APB psel/penable     | paddr, pwdata, prdata, pready
//
// For each sample the seconds (32 steps) and derivative (24 steps) divisions
// always run, the scaling division (24 steps) only outside the window and short
// of the left or right calibration point, where the measurement is not clamped.
// in_stall is high from acceptance until the result is written to the
// output register. The final step holds while the previous result is stalled.
// Reset clears the integral to zero and the previous error to minus one.
module steering_pid_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [spid_pkg::ADC_BITS-1:0]        position_sample,
	input  logic [11:0]                          left_command,
	input  logic [11:0]                          right_command,
	input  logic [31:0]                          elapsed_ticks,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [12:0]                   position_error,
	output logic signed [31:0]                   drive_value,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [spid_pkg::PADDR_W-1:0]         paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	import spid_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE    = 12'b000000000001,
		ST_SCL_GO  = 12'b000000000010,
		ST_SCL_WT  = 12'b000000000100,
		ST_SEC_GO  = 12'b000000001000,
		ST_SEC_WT  = 12'b000000010000,
		ST_INT_MUL = 12'b000000100000,
		ST_INT_SAT = 12'b000001000000,
		ST_DER_WT  = 12'b000010000000,
		ST_P_MUL   = 12'b000100000000,
		ST_I_MUL   = 12'b001000000000,
		ST_D_MUL   = 12'b010000000000,
		ST_FIN     = 12'b100000000000
	} state_t;

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	state_t             state_q;
	logic [11:0]        pos_q;
	logic [31:0]        ticks_q;
	logic signed [12:0] sp_q;
	logic               up_q;
	logic signed [12:0] err_q;
	logic [31:0]        secs_q;
	logic signed [31:0] integral_q;
	logic signed [15:0] prev_q;
	logic signed [23:0] deriv_q;
	logic               dneg_q;
	logic signed [50:0] acc_q;
	logic               out_valid_q;
	logic signed [12:0] out_err_q;
	logic signed [31:0] out_drive_q;

	logic signed [16:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [50:0] prod;

	// input side
	logic               accept;
	logic [11:0]        raw;
	logic signed [12:0] sp_next;

	// scaling decisions
	logic        above, below, scl_div;
	logic [11:0] meas_direct;
	logic [11:0] meas_div;
	logic [11:0] ceil_q;

	logic signed [50:0] integ_sum;
	logic signed [31:0] integ_new;
	logic signed [16:0] diff;
	logic [16:0]        diff_abs;
	logic signed [50:0] sum_full;
	logic signed [31:0] sum_sat;
	logic               in_band;
	logic               out_free;

	spid_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	spid_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	spid_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.prod(prod)
	);

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign raw      = 12'(position_sample);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		if (right_command > COMMAND_LIMIT)
			sp_next = $signed({1'b0, MID_SCALE}) - $signed({2'b00, right_command[11:1]});
		else if (left_command > COMMAND_LIMIT)
			sp_next = $signed({1'b0, MID_SCALE}) + $signed({2'b00, left_command[11:1]});
		else
			sp_next = $signed({1'b0, MID_SCALE});
	end

	assign above = {1'b0, pos_q} > ({1'b0, cfg.pot_middle} + WINDOW);
	assign below = ({1'b0, pos_q} + WINDOW) < {1'b0, cfg.pot_middle};

	always_comb begin
		scl_div     = 1'b0;
		meas_direct = pos_q;
		if (above) begin
			if (pos_q >= cfg.pot_left)
				meas_direct = FULL_SCALE;
			else
				scl_div = 1'b1;
		end else if (below) begin
			if (pos_q <= cfg.pot_right)
				meas_direct = 12'd0;
			else
				scl_div = 1'b1;
		end
	end

	// quotient stays below 2048 above the window and at most 2048 below it
	assign ceil_q   = div_rsp.quot[11:0] + {11'h0, (div_rsp.rem != '0)};
	assign meas_div = up_q ? (MID_SCALE + div_rsp.quot[11:0]) : (MID_SCALE - ceil_q);

	assign diff     = 17'(err_q) - 17'(prev_q);
	assign diff_abs = diff[16] ? 17'(-diff) : 17'(diff);

	assign integ_sum = 51'(integral_q) + prod;
	assign integ_new = sat32(integ_sum);

	assign sum_full = acc_q + (prod >>> 8);
	assign sum_sat  = sat32(sum_full);
	assign in_band  = (err_q > -DEADBAND) && (err_q < DEADBAND);

	always_comb begin
		div_req.start    = 1'b0;
		div_req.short_op = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		case (state_q)
			ST_SCL_GO: begin
				div_req.start    = scl_div;
				div_req.short_op = 1'b1;
				div_req.dividend = above ? {9'h0, pos_q - cfg.pot_middle, 11'h0}
				                         : {9'h0, cfg.pot_middle - pos_q, 11'h0};
				div_req.divisor  = above ? {21'h0, cfg.pot_left - cfg.pot_middle}
				                         : {21'h0, cfg.pot_middle - cfg.pot_right};
			end
			ST_SCL_WT: begin
				div_req.short_op = 1'b1;
				div_req.divisor  = up_q ? {21'h0, cfg.pot_left - cfg.pot_middle}
				                        : {21'h0, cfg.pot_middle - cfg.pot_right};
			end
			ST_SEC_GO, ST_SEC_WT: begin
				div_req.start    = (state_q == ST_SEC_GO);
				div_req.dividend = ticks_q;
				div_req.divisor  = (cfg.ticks_per_second == '0) ? 33'd1
				                   : {17'h0, cfg.ticks_per_second};
			end
			ST_INT_SAT, ST_DER_WT: begin
				div_req.start    = (state_q == ST_INT_SAT);
				div_req.short_op = 1'b1;
				div_req.dividend = {8'h0, diff_abs[15:0], 8'h00};
				div_req.divisor  = {1'b0, secs_q} + 33'd1;
			end
			default: ;
		endcase
	end

	always_comb begin
		mul_a = 17'(err_q);
		mul_b = {2'b00, secs_q};
		case (state_q)
			ST_P_MUL: begin
				mul_a = 17'(cfg.gain_p);
				mul_b = 34'(err_q);
			end
			ST_I_MUL: begin
				mul_a = 17'(cfg.gain_i);
				mul_b = 34'(integral_q);
			end
			// keep the derivative product steady while the final step holds
			ST_D_MUL, ST_FIN: begin
				mul_a = 17'(cfg.gain_d);
				mul_b = 34'(deriv_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			integral_q  <= '0;
			prev_q      <= -16'sd1;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_SCL_GO;
				end
				ST_SCL_GO: begin
					state_q <= scl_div ? ST_SCL_WT : ST_SEC_GO;
				end
				ST_SCL_WT: begin
					if (div_rsp.done)
						state_q <= ST_SEC_GO;
				end
				ST_SEC_GO: state_q <= ST_SEC_WT;
				ST_SEC_WT: begin
					if (div_rsp.done)
						state_q <= ST_INT_MUL;
				end
				ST_INT_MUL: state_q <= ST_INT_SAT;
				ST_INT_SAT: begin
					integral_q <= integ_new;
					state_q    <= ST_DER_WT;
				end
				ST_DER_WT: begin
					if (div_rsp.done)
						state_q <= ST_P_MUL;
				end
				ST_P_MUL: state_q <= ST_I_MUL;
				ST_I_MUL: state_q <= ST_D_MUL;
				ST_D_MUL: state_q <= ST_FIN;
				ST_FIN: begin
					// hold until the previous result has gone
					if (out_free) begin
						prev_q  <= 16'(err_q);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					pos_q   <= raw;
					ticks_q <= elapsed_ticks;
					sp_q    <= sp_next;
				end
			end
			ST_SCL_GO: begin
				up_q  <= above;
				err_q <= $signed({1'b0, meas_direct}) - sp_q;
			end
			ST_SCL_WT: begin
				if (div_rsp.done)
					err_q <= $signed({1'b0, meas_div}) - sp_q;
			end
			ST_SEC_WT: begin
				if (div_rsp.done)
					secs_q <= div_rsp.quot;
			end
			ST_INT_SAT: dneg_q <= diff[16];
			ST_DER_WT: begin
				if (div_rsp.done)
					deriv_q <= dneg_q ? 24'(-$signed({1'b0, div_rsp.quot[22:0]}))
					                  : $signed({1'b0, div_rsp.quot[22:0]});
			end
			ST_I_MUL: acc_q <= prod;
			ST_D_MUL: acc_q <= acc_q + prod;
			ST_FIN: begin
				if (out_free) begin
					out_err_q   <= err_q;
					out_drive_q <= in_band ? 32'sd0 : sum_sat;
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign position_error = out_err_q;
	assign drive_value    = out_drive_q;
endmodule

### hw/rtl/spid_chk.sv
// Port-level checker for the steering PID controller, bound to the top level.
// No package dependency.
module spid_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [12:0] position_error,
	input logic signed [31:0] drive_value
);
	// a stalled result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(drive_value)
			&& $stable(position_error))
		else $error("stalled result changed");

	// the block is busy right after a sample transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("ready straight after a transfer");

	// a result never appears in the cycle after a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result too early");

	// drive is zero inside the deadband
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (position_error > -13'sd400) && (position_error < 13'sd400)
			|-> drive_value == 32'sd0)
		else $error("drive not zero in deadband");
endmodule

bind steering_pid_controller spid_chk u_spid_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.position_error(position_error),
	.drive_value   (drive_value)
);
